// File: rtl/core/stq_pkg.sv
// ---------------------------------------------------------------------------
// stq_pkg
// Types, codes and constants shared by the sorted timer queue modules.
// ---------------------------------------------------------------------------
package stq_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int ID_W            = 32;
    localparam int TIME_W          = 64;
    localparam int DELAY_W         = 32;
    localparam int OWNER_W         = 8;
    localparam int TAG_W           = 32;
    localparam int WIN_W           = 10;
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_STOP   = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_EXPIRY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // One input item
    typedef struct packed {
        cmd_t               cmd;
        logic [DELAY_W-1:0] delay_ms;
        logic [ID_W-1:0]    timer_id;
        logic [OWNER_W-1:0] owner;
        logic [TAG_W-1:0]   tag;
    } request_t;

    // One result item
    typedef struct packed {
        kind_t              kind;
        status_t            status;
        logic [ID_W-1:0]    result_id;
        logic [OWNER_W-1:0] result_owner;
        logic [TAG_W-1:0]   result_tag;
        logic               running;
        logic               last;
    } result_t;

    // Contents of one table slot
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  expiry;
        logic [OWNER_W-1:0] owner;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t        op;
        logic [ID_W-1:0] tid;
        entry_t          ins;
    } cell_ctl_t;

endpackage

// File: rtl/core/stq_cell.sv
// ---------------------------------------------------------------------------
// stq_cell
// One slot of the sorted chain: holds an entry, compares it against the
// broadcast key and id, and takes its own, the new or a neighbour's entry.
// ---------------------------------------------------------------------------
module stq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  stq_pkg::cell_ctl_t ctl,
    input  logic               rm,
    input  logic               left_gt,
    input  logic               left_valid,
    input  stq_pkg::entry_t    left_entry,
    input  logic               right_valid,
    input  stq_pkg::entry_t    right_entry,
    output stq_pkg::entry_t    entry,
    output logic               valid,
    output logic               gt,
    output logic               match
);

    stq_pkg::entry_t entry_reg;
    logic            valid_reg;

    // empty slots count as later than any key
    assign gt    = !valid_reg || (entry_reg.expiry > ctl.ins.expiry);
    assign match = valid_reg && (entry_reg.id == ctl.tid);
    assign entry = entry_reg;
    assign valid = valid_reg;

    // slot contents
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            stq_pkg::CELL_INSERT:
            begin
                if (left_gt)
                    entry_reg <= left_entry;
                else if (gt)
                    entry_reg <= ctl.ins;
            end
            stq_pkg::CELL_REMOVE:
            begin
                if (rm)
                    entry_reg <= right_entry;
            end
            default:
            begin
                entry_reg <= entry_reg;
            end
        endcase
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
        begin
            case (ctl.op)
                stq_pkg::CELL_INSERT:
                begin
                    if (left_gt)
                        valid_reg <= left_valid;
                    else if (gt)
                        valid_reg <= 1'b1;
                end
                stq_pkg::CELL_REMOVE:
                begin
                    if (rm)
                        valid_reg <= right_valid;
                end
                default:
                begin
                    valid_reg <= valid_reg;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/stq_ctrl.sv
// ---------------------------------------------------------------------------
// stq_ctrl
// Command sequencer: time and id counters, early window register, cell
// broadcast, expiry drain and the registered result port.
// ---------------------------------------------------------------------------
module stq_ctrl #(
    parameter int TABLE_DEPTH = stq_pkg::TABLE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  stq_pkg::request_t         request,
    output logic                      done,
    output stq_pkg::result_t          result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [stq_pkg::WIN_W-1:0] cfg_data,
    output stq_pkg::cell_ctl_t        cell_ctl,
    output logic [TABLE_DEPTH-1:0]    rm_mask,
    input  logic [TABLE_DEPTH-1:0]    valid_vec,
    input  logic [TABLE_DEPTH-1:0]    match_vec,
    input  stq_pkg::entry_t           head_entry
);

    localparam int CNT_W = $clog2(stq_pkg::MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY,
        S_DRAIN
    } state_t;

    state_t                          state_reg;
    stq_pkg::request_t               req_reg;
    logic [stq_pkg::ID_W-1:0]        id_reg;
    logic [stq_pkg::TIME_W-1:0]      now_reg;
    logic [stq_pkg::TIME_W-1:0]      exp_reg;
    logic [stq_pkg::WIN_W-1:0]       window_reg;
    logic [TABLE_DEPTH-1:0]          match_reg;
    stq_pkg::entry_t                 pend_reg;
    logic                            pend_vld_reg;
    logic [CNT_W-1:0]                n_reg;
    logic                            done_reg;
    stq_pkg::result_t                result_reg;
    logic [stq_pkg::ID_W-1:0]        id_next;
    logic [stq_pkg::TIME_W-1:0]      remain;
    logic                            head_due;
    logic                            take;
    logic                            found;
    logic                            full;

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;
    assign full      = valid_vec[TABLE_DEPTH-1];
    assign found     = |match_reg;

    // next id: wraps and skips zero
    assign id_next = (id_reg + 1'b1 == '0) ? stq_pkg::ID_W'(1) : id_reg + 1'b1;

    // head entry due test against the advanced time
    assign remain   = head_entry.expiry - now_reg;
    assign head_due = valid_vec[0] &&
                      ((head_entry.expiry <= now_reg) ||
                       (remain <= {{(stq_pkg::TIME_W-stq_pkg::WIN_W){1'b0}}, window_reg}));
    assign take     = (state_reg == S_DRAIN) && head_due &&
                      (n_reg < CNT_W'(stq_pkg::MAX_RESULTS));

    // cell broadcast
    always_comb
    begin
        logic acc;
        acc              = 1'b0;
        cell_ctl.op      = stq_pkg::CELL_HOLD;
        cell_ctl.tid     = req_reg.timer_id;
        cell_ctl.ins.id     = id_reg;
        cell_ctl.ins.expiry = exp_reg;
        cell_ctl.ins.owner  = req_reg.owner;
        cell_ctl.ins.tag    = req_reg.tag;
        // every slot from the first match onwards moves up by one
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            acc        = acc | match_reg[i];
            rm_mask[i] = acc;
        end
        if (state_reg == S_APPLY)
        begin
            if (req_reg.cmd == stq_pkg::CMD_START && !full)
                cell_ctl.op = stq_pkg::CELL_INSERT;
            else if (req_reg.cmd == stq_pkg::CMD_STOP && found)
                cell_ctl.op = stq_pkg::CELL_REMOVE;
        end
        else if (take)
        begin
            cell_ctl.op = stq_pkg::CELL_REMOVE;
            rm_mask     = '1;
        end
    end

    // sequencer, counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            req_reg      <= '0;
            id_reg       <= '0;
            now_reg      <= '0;
            exp_reg      <= '0;
            window_reg   <= stq_pkg::WINDOW_RESET;
            match_reg    <= '0;
            pend_reg     <= '0;
            pend_vld_reg <= 1'b0;
            n_reg        <= '0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                window_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        req_reg   <= request;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    done_reg  <= 1'b0;
                    match_reg <= match_vec;
                    case (req_reg.cmd)
                        stq_pkg::CMD_START:
                        begin
                            id_reg    <= id_next;
                            exp_reg   <= now_reg +
                                         {{(stq_pkg::TIME_W-stq_pkg::DELAY_W){1'b0}},
                                          req_reg.delay_ms};
                            state_reg <= S_APPLY;
                        end
                        stq_pkg::CMD_TICK:
                        begin
                            now_reg      <= now_reg + 1'b1;
                            n_reg        <= '0;
                            pend_vld_reg <= 1'b0;
                            state_reg    <= S_DRAIN;
                        end
                        default:
                        begin
                            state_reg <= S_APPLY;
                        end
                    endcase
                end
                S_APPLY:
                begin
                    done_reg                <= 1'b1;
                    result_reg.result_owner <= '0;
                    result_reg.result_tag   <= '0;
                    result_reg.last         <= 1'b1;
                    case (req_reg.cmd)
                        stq_pkg::CMD_START:
                        begin
                            result_reg.kind    <= stq_pkg::KIND_START;
                            result_reg.running <= 1'b0;
                            if (full)
                            begin
                                result_reg.status    <= stq_pkg::ST_FULL;
                                result_reg.result_id <= '0;
                            end
                            else
                            begin
                                result_reg.status    <= stq_pkg::ST_OK;
                                result_reg.result_id <= id_reg;
                            end
                        end
                        stq_pkg::CMD_STOP:
                        begin
                            result_reg.kind      <= stq_pkg::KIND_STOP;
                            result_reg.result_id <= req_reg.timer_id;
                            result_reg.running   <= 1'b0;
                            result_reg.status    <= found ? stq_pkg::ST_OK
                                                          : stq_pkg::ST_NOT_FOUND;
                        end
                        default:
                        begin
                            result_reg.kind      <= stq_pkg::KIND_QUERY;
                            result_reg.result_id <= req_reg.timer_id;
                            result_reg.status    <= found ? stq_pkg::ST_OK
                                                          : stq_pkg::ST_NOT_FOUND;
                            result_reg.running   <= found;
                        end
                    endcase
                    state_reg <= S_IDLE;
                end
                S_DRAIN:
                begin
                    // the held expiry goes out once we know whether another follows
                    done_reg <= pend_vld_reg;
                    if (pend_vld_reg)
                    begin
                        result_reg.kind         <= stq_pkg::KIND_EXPIRY;
                        result_reg.status       <= stq_pkg::ST_OK;
                        result_reg.result_id    <= pend_reg.id;
                        result_reg.result_owner <= pend_reg.owner;
                        result_reg.result_tag   <= pend_reg.tag;
                        result_reg.running      <= 1'b0;
                        result_reg.last         <= !take;
                    end
                    if (take)
                    begin
                        pend_reg     <= head_entry;
                        pend_vld_reg <= 1'b1;
                        n_reg        <= n_reg + 1'b1;
                    end
                    else
                    begin
                        pend_vld_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted item");

    a_reply_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.kind != stq_pkg::KIND_EXPIRY) |-> result.last)
        else $error("command reply without last mark");

    a_expiry_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.kind == stq_pkg::KIND_EXPIRY && !result.last) |=> done)
        else $error("gap inside an expiry burst");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_ctl.op == stq_pkg::CELL_INSERT) |-> !full)
        else $error("insert into a full table");

    a_packed_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + TABLE_DEPTH'(1))) == '0)
        else $error("occupied slots not packed from the head");
`endif

endmodule

// File: rtl/core/sorted_timer_queue_top.sv
// ---------------------------------------------------------------------------
// sorted_timer_queue_top
// Sorted one-shot millisecond timer table built as a chain of slot cells.
// ---------------------------------------------------------------------------
// Usage:
//   An item (request) is taken at a rising edge with start high and busy
//   low. Commands: start a timer, stop one by id, query an id, or a one
//   millisecond tick. Results appear on result for one cycle with done high;
//   the receiver cannot stall, so it must take every result as it comes.
//   Start, stop and query: one reply, with done high after the EVAL and
//   APPLY states; busy drops in that same cycle, so the next item can be
//   taken while the reply is shown. The chain compares and shifts all
//   slots at once: the cells insert or remove in the APPLY state, after
//   the EVAL state has formed the expiry key or registered the id match.
//   Tick: time advances in the EVAL state, then one due head entry leaves
//   the chain per cycle (at most 16 per tick); expiries stream on
//   consecutive cycles, the final one with last set. A tick with nothing
//   due gives no result. The user must write the early window register
//   over cfg_valid/cfg_data (cfg_ready always high) only while idle; the
//   block itself does not enforce this.
//   Reset empties the table, clears time and the id counter, window = 8.
// ---------------------------------------------------------------------------
module sorted_timer_queue_top #(
    parameter int TABLE_DEPTH = stq_pkg::TABLE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  stq_pkg::request_t         request,
    output logic                      done,
    output stq_pkg::result_t          result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [stq_pkg::WIN_W-1:0] cfg_data
);

    stq_pkg::cell_ctl_t     cell_ctl;
    logic [TABLE_DEPTH-1:0] rm_mask;
    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH-1:0] gt_vec;
    logic [TABLE_DEPTH-1:0] match_vec;
    stq_pkg::entry_t        entry_vec [TABLE_DEPTH];

    stq_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .cell_ctl   (cell_ctl),
        .rm_mask    (rm_mask),
        .valid_vec  (valid_vec),
        .match_vec  (match_vec),
        .head_entry (entry_vec[0])
    );

    // slot chain: each cell sees its left and right neighbour
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic            l_gt;
        logic            l_valid;
        stq_pkg::entry_t l_entry;
        logic            r_valid;
        stq_pkg::entry_t r_entry;

        if (i == 0)
        begin : g_head
            assign l_gt    = 1'b0;
            assign l_valid = 1'b0;
            assign l_entry = '0;
        end
        else
        begin : g_mid
            assign l_gt    = gt_vec[i-1];
            assign l_valid = valid_vec[i-1];
            assign l_entry = entry_vec[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_entry = '0;
        end
        else
        begin : g_body
            assign r_valid = valid_vec[i+1];
            assign r_entry = entry_vec[i+1];
        end

        stq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl),
            .rm          (rm_mask[i]),
            .left_gt     (l_gt),
            .left_valid  (l_valid),
            .left_entry  (l_entry),
            .right_valid (r_valid),
            .right_entry (r_entry),
            .entry       (entry_vec[i]),
            .valid       (valid_vec[i]),
            .gt          (gt_vec[i]),
            .match       (match_vec[i])
        );
    end

endmodule

// File: dv/sorted_timer_queue_top_test.sv
// ---------------------------------------------------------------------------
// sorted_timer_queue_top_test
// Self-checking bench for the sorted one-shot timer table.
// ---------------------------------------------------------------------------
// Start, stop, query and tick items go in through the start/busy port. The
// bench keeps its own sorted copy of the table, the clock and the id counter,
// and works out the replies and expiries for every accepted item. Each
// strobed result is compared field by field with the oldest one expected.
// Directed tests cover an empty tick, id lookups, the early window boundary
// and a full table. Random phases then run under several window settings.
// ---------------------------------------------------------------------------
module sorted_timer_queue_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stq_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE      = 20;
    localparam int IDLE_SPARE  = 4;
    localparam int MAX_REPORTS = 10;
    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int PHASE_ITEMS = 23;

    // DUT connections
    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    request_t           request;
    logic               done;
    result_t            result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [WIN_W-1:0]   cfg_data;

    // Bench copy of the timer state
    entry_t             timer_table[$];
    logic [TIME_W-1:0]  clock_ms     = '0;
    logic [ID_W-1:0]    id_counter   = '0;
    logic [WIN_W-1:0]   early_window = WINDOW_RESET;
    result_t            expected_results[$];
    logic [ID_W-1:0]    long_timer_id;

    // Run statistics
    int error_count     = 0;
    int cycle_count     = 0;
    int starts_sent     = 0;
    int stops_sent      = 0;
    int queries_sent    = 0;
    int ticks_sent      = 0;
    int full_replies    = 0;
    int results_checked = 0;
    int expiries_seen   = 0;
    int windows_written = 0;

    sorted_timer_queue_top #(
        .TABLE_DEPTH (DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Timer table prediction
    // ------------------------------------------------------------------
    function automatic int find_timer(logic [ID_W-1:0] tid);
        for (int i = 0; i < timer_table.size(); i++)
        begin
            if (timer_table[i].id == tid)
                return i;
        end
        return -1;
    endfunction

    // Head is due when past, or within the early window
    function automatic logic head_is_due();
        logic [TIME_W-1:0] exp_ms;
        exp_ms = timer_table[0].expiry;
        if (exp_ms <= clock_ms)
            return 1'b1;
        return (exp_ms - clock_ms) <= TIME_W'(early_window);
    endfunction

    // Update the table for one accepted item and queue the results it causes
    function automatic void apply_request(request_t req);
        result_t r;
        entry_t  e;
        int      pos;
        int      hit;
        int      n;
        r      = '0;
        r.last = 1'b1;
        case (req.cmd)
            CMD_START:
            begin
                starts_sent++;
                id_counter = id_counter + 1'b1;
                if (id_counter == '0)
                    id_counter = id_counter + 1'b1;
                r.kind = KIND_START;
                if (timer_table.size() >= DEPTH)
                begin
                    r.status = ST_FULL;
                    full_replies++;
                end
                else
                begin
                    e.id     = id_counter;
                    e.expiry = clock_ms + TIME_W'(req.delay_ms);
                    e.owner  = req.owner;
                    e.tag    = req.tag;
                    // equal expiry goes behind the existing entries
                    pos = 0;
                    while (pos < timer_table.size() && timer_table[pos].expiry <= e.expiry)
                        pos++;
                    timer_table.insert(pos, e);
                    r.status    = ST_OK;
                    r.result_id = id_counter;
                end
                expected_results.push_back(r);
            end
            CMD_STOP, CMD_QUERY:
            begin
                hit         = find_timer(req.timer_id);
                r.kind      = (req.cmd == CMD_STOP) ? KIND_STOP : KIND_QUERY;
                r.status    = (hit < 0) ? ST_NOT_FOUND : ST_OK;
                r.result_id = req.timer_id;
                if (req.cmd == CMD_STOP)
                begin
                    stops_sent++;
                    if (hit >= 0)
                        timer_table.delete(hit);
                end
                else
                begin
                    queries_sent++;
                    r.running = (hit >= 0);
                end
                expected_results.push_back(r);
            end
            CMD_TICK:
            begin
                ticks_sent++;
                clock_ms = clock_ms + 1'b1;
                n = 0;
                while (n < MAX_RESULTS && timer_table.size() > 0 && head_is_due())
                begin
                    e              = timer_table.pop_front();
                    r              = '0;
                    r.kind         = KIND_EXPIRY;
                    r.status       = ST_OK;
                    r.result_id    = e.id;
                    r.result_owner = e.owner;
                    r.result_tag   = e.tag;
                    expected_results.push_back(r);
                    n++;
                end
                // mark the final expiry of this tick
                if (n > 0)
                begin
                    r      = expected_results.pop_back();
                    r.last = 1'b1;
                    expected_results.push_back(r);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic string describe(result_t r);
        return $sformatf("kind=%0d status=%0d id=%h owner=%h tag=%h running=%b last=%b",
                         r.kind, r.status, r.result_id, r.result_owner, r.result_tag,
                         r.running, r.last);
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            results_checked++;
            if (result.kind == KIND_EXPIRY)
                expiries_seen++;
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result with none expected: %s", $realtime, describe(result));
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.kind !== want.kind || result.status !== want.status
                    || result.result_id !== want.result_id
                    || result.result_owner !== want.result_owner
                    || result.result_tag !== want.result_tag
                    || result.running !== want.running || result.last !== want.last)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                 $realtime, describe(want), describe(result));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // start stays high into the next item; idle and drain lower it
    task automatic send_item(request_t req);
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        apply_request(req);
    endtask

    task automatic idle_burst(int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Hold off until every expected result is in and the block is quiet
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() > 0)
            @(negedge clk);
        repeat (IDLE_SPARE) @(negedge clk);
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic write_window(logic [WIN_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        early_window = value;
        windows_written++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic request_t make_request(cmd_t cmd, logic [DELAY_W-1:0] delay,
                                              logic [ID_W-1:0] tid,
                                              logic [OWNER_W-1:0] own,
                                              logic [TAG_W-1:0] user_tag);
        request_t req;
        req.cmd      = cmd;
        req.delay_ms = delay;
        req.timer_id = tid;
        req.owner    = own;
        req.tag      = user_tag;
        return req;
    endfunction

    // Mostly short delays and live ids; unused fields stay fully random
    function automatic request_t random_request();
        request_t req;
        int       roll;
        req.delay_ms = $urandom();
        req.timer_id = $urandom();
        req.owner    = OWNER_W'($urandom());
        req.tag      = $urandom();
        roll = $urandom_range(0, 99);
        if (roll < 35)
            req.cmd = CMD_START;
        else if (roll < 70)
            req.cmd = CMD_TICK;
        else if (roll < 85)
            req.cmd = CMD_STOP;
        else
            req.cmd = CMD_QUERY;
        roll = $urandom_range(0, 9);
        if (req.cmd == CMD_START)
        begin
            if (roll < 6)
                req.delay_ms = $urandom_range(0, 12);
            else if (roll < 9)
                req.delay_ms = DELAY_W'(early_window) + $urandom_range(0, 3);
        end
        else if (req.cmd == CMD_STOP || req.cmd == CMD_QUERY)
        begin
            if (roll < 6 && timer_table.size() > 0)
                req.timer_id = timer_table[$urandom_range(0, timer_table.size() - 1)].id;
            else if (roll < 8)
                req.timer_id = id_counter;
            else if (roll == 8)
                req.timer_id = '0;
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Tick on an empty table gives nothing back
    task automatic test_empty_tick();
        send_item(make_request(CMD_TICK, '0, '0, '0, '0));
    endtask

    // Start, query and stop by id, then the early window boundary
    task automatic test_commands();
        logic [ID_W-1:0] short_id;
        send_item(make_request(CMD_START, '1, '0, '1, '1));
        long_timer_id = id_counter;
        send_item(make_request(CMD_START, '0, '0, OWNER_W'($urandom()), $urandom()));
        short_id = id_counter;
        send_item(make_request(CMD_QUERY, '0, short_id, '0, '0));
        send_item(make_request(CMD_QUERY, '0, '0, '0, '0));
        send_item(make_request(CMD_STOP, '0, '1, '0, '0));
        send_item(make_request(CMD_STOP, '0, short_id, '0, '0));
        send_item(make_request(CMD_QUERY, '0, short_id, '0, '0));
        // two beyond the window: due on the second tick, not the first
        send_item(make_request(CMD_START, DELAY_W'(early_window) + 2, '0,
                               OWNER_W'($urandom()), $urandom()));
        send_item(make_request(CMD_TICK, '0, '0, '0, '0));
        send_item(make_request(CMD_TICK, '0, '0, '0, '0));
        wait_idle();
    endtask

    // Fill with equal expiries, overflow once, drain in one tick
    task automatic test_table_full();
        while (timer_table.size() < DEPTH)
            send_item(make_request(CMD_START, '0, '0, OWNER_W'($urandom()), $urandom()));
        send_item(make_request(CMD_START, '0, '0, '1, '1));
        send_item(make_request(CMD_TICK, '0, '0, '0, '0));
        send_item(make_request(CMD_STOP, '0, long_timer_id, '0, '0));
    endtask

    task automatic test_random_phase(logic [WIN_W-1:0] window, int count, bit with_gaps);
        write_window(window);
        repeat (count)
        begin
            if (with_gaps && $urandom_range(0, 3) == 0)
                idle_burst($urandom_range(1, 14));
            send_item(random_request());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        int guard;
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_tick();
        test_commands();
        test_table_full();
        test_random_phase('0, PHASE_ITEMS, 1'b1);
        test_random_phase('1, PHASE_ITEMS, 1'b1);
        test_random_phase(WIN_W'($urandom_range(1, 1000)), PHASE_ITEMS, 1'b1);
        // closing stretch without gaps
        test_random_phase(WINDOW_RESET, PHASE_ITEMS, 1'b0);

        @(negedge clk);
        start <= 1'b0;
        guard = 0;
        while (expected_results.size() > 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
        if (expected_results.size() > 0)
        begin
            $display("%0d expected results never arrived", expected_results.size());
            error_count += expected_results.size();
        end

        $display("items: %0d starts (%0d on a full table), %0d stops, %0d queries, %0d ticks",
                 starts_sent, full_replies, stops_sent, queries_sent, ticks_sent);
        $display("checked %0d results, %0d expiries, over %0d window settings; %0d errors",
                 results_checked, expiries_seen, windows_written, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/stq_pkg.sv
rtl/core/stq_cell.sv
rtl/core/stq_ctrl.sv
rtl/core/sorted_timer_queue_top.sv
dv/sorted_timer_queue_top_test.sv
